[rtl/bcdt_pkg.sv]
`timescale 1ns / 1ps

package bcdt_pkg;

   // time constants
   localparam logic [16:0] DAY_SECONDS  = 17'd86400;
   localparam logic [11:0] HOUR_SECONDS = 12'd3600;
   localparam logic [5:0]  MIN_SECONDS  = 6'd60;

   // reciprocals for divide by constant (estimate low by at most one)
   localparam logic [10:0] HOUR_RECIP = 11'd1165;   // ~ 2^22 / 3600
   localparam int          HOUR_SHIFT = 22;
   localparam logic [10:0] MIN_RECIP  = 11'd1092;   // ~ 2^16 / 60
   localparam int          MIN_SHIFT  = 16;

   // pipeline stages
   localparam int NUM_STAGES = 6;
   localparam int ST_DECODE  = 0;   // BCD decode, weighted sum, stamp wrap
   localparam int ST_WRAP    = 1;   // wrap now and alarm sum at one day
   localparam int ST_ELAPSED = 2;   // elapsed time, hour estimate
   localparam int ST_HOUR    = 3;   // hour correction, seconds in hour
   localparam int ST_MINUTE  = 4;   // minute estimate
   localparam int ST_OUT     = 5;   // minute correction, BCD packing

   // date mask bit of the alarm word
   localparam logic [7:0] ALARM_TOP_BYTE = 8'h80;

   // stage enables and valids from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] vld;
   } pipe_ctl_type;

   // front end result handed to the split stages
   typedef struct packed {
      logic [16:0] now_seconds;
      logic [16:0] elapsed_seconds;
      logic [16:0] alarm_sum;
      logic [4:0]  hour_est;
   } front_type;

   // final result word
   typedef struct packed {
      logic [16:0] now_seconds;
      logic [16:0] elapsed_seconds;
      logic [31:0] alarm_word;
   } result_type;

   // binary 0..63 to packed BCD, tens by multiply with 205 / 2^11
   function automatic logic [7:0] bcd_encode(input logic [5:0] v);
      logic [13:0] prod;
      logic [2:0]  tens;
      logic [3:0]  units;
      prod  = 14'(v) * 14'd205;
      tens  = prod[13:11];
      units = 4'(v - 6'(tens) * 6'd10);
      return {1'b0, tens, units};
   endfunction

endpackage

[rtl/bcdt_if.sv]
`timescale 1ns / 1ps

// input word: one clock reading plus stamps
interface bcdt_req_if;
   logic        valid;
   logic        ready;
   logic [6:0]  sec_bcd;
   logic [6:0]  min_bcd;
   logic [5:0]  hour_bcd;
   logic [16:0] ref_stamp;
   logic [15:0] alarm_offset;

   modport source (output valid, sec_bcd, min_bcd, hour_bcd, ref_stamp, alarm_offset,
                   input ready);
   modport sink   (input valid, sec_bcd, min_bcd, hour_bcd, ref_stamp, alarm_offset,
                   output ready);
endinterface

// result word
interface bcdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] now_seconds;
   logic [16:0] elapsed_seconds;
   logic [31:0] alarm_word;

   modport source (output valid, now_seconds, elapsed_seconds, alarm_word,
                   input ready);
   modport sink   (input valid, now_seconds, elapsed_seconds, alarm_word,
                   output ready);
endinterface

[rtl/bcdt_pipe_ctl.sv]
`timescale 1ns / 1ps

module bcdt_pipe_ctl
   import bcdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic         out_ready,
   output pipe_ctl_type ctl
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   rdy;

   // per-stage ready: a stage loads when empty or when its word moves on
   always_comb begin
      rdy[NUM_STAGES] = out_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = ~vld_ff[i] | rdy[i+1];
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (rdy[i]) begin
            vld_in[i] = (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready = rdy[0];
   assign ctl.en   = rdy[NUM_STAGES-1:0];
   assign ctl.vld  = vld_ff;

endmodule

[rtl/bcdt_front.sv]
`timescale 1ns / 1ps

module bcdt_front
   import bcdt_pkg::*;
(
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  logic [6:0]   sec_bcd,
   input  logic [6:0]   min_bcd,
   input  logic [5:0]   hour_bcd,
   input  logic [16:0]  ref_stamp,
   input  logic [15:0]  alarm_offset,
   input  logic [16:0]  event_stamp,   // already below one day
   output front_type    front
);

   // decode stage
   logic [17:0] now_raw_ff, now_raw_in;
   logic [16:0] ref0_ff, ref0_in;
   logic [17:0] sum_raw_ff, sum_raw_in;
   // wrap stage
   logic [16:0] now1_ff, now1_in;
   logic [16:0] ref1_ff;
   logic [16:0] sum1_ff, sum1_in;
   // elapsed stage
   logic [16:0] now2_ff;
   logic [16:0] elapsed2_ff, elapsed2_in;
   logic [16:0] sum2_ff;
   logic [4:0]  hour2_ff, hour2_in;

   logic [6:0]  sec_bin, min_bin;
   logic [5:0]  hour_bin;
   logic [27:0] hour_prod;

   // BCD digits to binary, no digit check
   always_comb begin
      sec_bin  = 7'(sec_bcd[6:4]) * 7'd10 + 7'(sec_bcd[3:0]);
      min_bin  = 7'(min_bcd[6:4]) * 7'd10 + 7'(min_bcd[3:0]);
      hour_bin = 6'(hour_bcd[5:4]) * 6'd10 + 6'(hour_bcd[3:0]);
      now_raw_in = 18'(hour_bin) * 18'(HOUR_SECONDS) + 18'(min_bin) * 18'(MIN_SECONDS)
                   + 18'(sec_bin);
      ref0_in    = (ref_stamp >= DAY_SECONDS) ? 17'(ref_stamp - DAY_SECONDS) : ref_stamp;
      sum_raw_in = 18'(event_stamp) + 18'(alarm_offset);
   end

   // wrap at one day, both stay below two days
   always_comb begin
      now1_in = (now_raw_ff >= 18'(DAY_SECONDS)) ? 17'(now_raw_ff - 18'(DAY_SECONDS))
                                                 : now_raw_ff[16:0];
      sum1_in = (sum_raw_ff >= 18'(DAY_SECONDS)) ? 17'(sum_raw_ff - 18'(DAY_SECONDS))
                                                 : sum_raw_ff[16:0];
   end

   // elapsed across midnight, hour estimate by reciprocal
   always_comb begin
      elapsed2_in = (now1_ff >= ref1_ff) ? 17'(now1_ff - ref1_ff)
                                         : 17'(now1_ff + DAY_SECONDS - ref1_ff);
      hour_prod   = 28'(sum1_ff) * 28'(HOUR_RECIP);
      hour2_in    = hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ST_DECODE]) begin
         now_raw_ff <= now_raw_in;
         ref0_ff    <= ref0_in;
         sum_raw_ff <= sum_raw_in;
      end
      if (ctl.en[ST_WRAP]) begin
         now1_ff <= now1_in;
         ref1_ff <= ref0_ff;
         sum1_ff <= sum1_in;
      end
      if (ctl.en[ST_ELAPSED]) begin
         now2_ff     <= now1_ff;
         elapsed2_ff <= elapsed2_in;
         sum2_ff     <= sum1_ff;
         hour2_ff    <= hour2_in;
      end
   end

   assign front.now_seconds     = now2_ff;
   assign front.elapsed_seconds = elapsed2_ff;
   assign front.alarm_sum       = sum2_ff;
   assign front.hour_est        = hour2_ff;

endmodule

[rtl/bcdt_split.sv]
`timescale 1ns / 1ps

module bcdt_split
   import bcdt_pkg::*;
(
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  front_type    front,
   output result_type   result
);

   // hour stage
   logic [16:0] now3_ff, elapsed3_ff;
   logic [4:0]  hour3_ff, hour3_in;
   logic [11:0] rem3_ff, rem3_in;
   // minute stage
   logic [16:0] now4_ff, elapsed4_ff;
   logic [4:0]  hour4_ff;
   logic [11:0] rem4_ff;
   logic [5:0]  min4_ff, min4_in;
   // output stage
   logic [16:0] now5_ff, elapsed5_ff;
   logic [31:0] word5_ff, word5_in;

   logic [12:0] hour_rem;
   logic [21:0] min_prod;
   logic [6:0]  min_rem;
   logic [5:0]  min_fix, sec_fix;

   // seconds within the hour, estimate low by at most one hour
   always_comb begin
      hour_rem = 13'(front.alarm_sum - 17'(front.hour_est) * 17'(HOUR_SECONDS));
      if (hour_rem >= 13'(HOUR_SECONDS)) begin
         hour3_in = front.hour_est + 5'd1;
         rem3_in  = 12'(hour_rem - 13'(HOUR_SECONDS));
      end else begin
         hour3_in = front.hour_est;
         rem3_in  = hour_rem[11:0];
      end
   end

   // minute estimate
   always_comb begin
      min_prod = 22'(rem3_ff) * 22'(MIN_RECIP);
      min4_in  = min_prod[MIN_SHIFT+5:MIN_SHIFT];
   end

   // minute correction and BCD packing
   always_comb begin
      min_rem = 7'(rem4_ff - 12'(min4_ff) * 12'(MIN_SECONDS));
      if (min_rem >= 7'(MIN_SECONDS)) begin
         min_fix = min4_ff + 6'd1;
         sec_fix = 6'(min_rem - 7'(MIN_SECONDS));
      end else begin
         min_fix = min4_ff;
         sec_fix = min_rem[5:0];
      end
      word5_in = {ALARM_TOP_BYTE, bcd_encode(6'(hour4_ff)), bcd_encode(min_fix),
                  bcd_encode(sec_fix)};
   end

   always_ff @(posedge clock) begin
      if (ctl.en[ST_HOUR]) begin
         now3_ff     <= front.now_seconds;
         elapsed3_ff <= front.elapsed_seconds;
         hour3_ff    <= hour3_in;
         rem3_ff     <= rem3_in;
      end
      if (ctl.en[ST_MINUTE]) begin
         now4_ff     <= now3_ff;
         elapsed4_ff <= elapsed3_ff;
         hour4_ff    <= hour3_ff;
         rem4_ff     <= rem3_ff;
         min4_ff     <= min4_in;
      end
      if (ctl.en[ST_OUT]) begin
         now5_ff     <= now4_ff;
         elapsed5_ff <= elapsed4_ff;
         word5_ff    <= word5_in;
      end
   end

   assign result.now_seconds     = now5_ff;
   assign result.elapsed_seconds = elapsed5_ff;
   assign result.alarm_word      = word5_ff;

endmodule

[rtl/bcd_time_of_day_alarm_calc.sv]
`timescale 1ns / 1ps
// channel    dir  payload                                            handshake
// req_chan   in   sec_bcd, min_bcd, hour_bcd, ref_stamp, alarm_offset  valid/ready
// rsp_chan   out  now_seconds, elapsed_seconds, alarm_word              valid/ready
// csr_*      in   event_stamp (17 bits)                                 write enable
//
// Six-stage pipeline: one word accepted per cycle unless a stall backs up to the input.
// Stages in order: decode, day wrap, elapsed and hour estimate, hour correction, minute estimate, BCD pack.
// Synchronous active-high reset clears the valid bits and event_stamp.
// Each stage holds its word while the next one is full and stalled; bubbles
// close up, so input is taken whenever any stage has room.

module bcd_time_of_day_alarm_calc
   import bcdt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   bcdt_req_if.sink       req_chan,
   bcdt_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic [16:0]    csr_wr_data
);

   logic [16:0]  event_ff, event_in;
   pipe_ctl_type ctl;
   front_type    front;
   result_type   result;

   // event stamp, stored already wrapped to one day
   always_comb begin
      event_in = event_ff;
      if (csr_wr_en) begin
         event_in = (csr_wr_data >= DAY_SECONDS) ? 17'(csr_wr_data - DAY_SECONDS)
                                                 : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff <= '0;
      end else begin
         event_ff <= event_in;
      end
   end

   // stage valids and enables
   bcdt_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // seconds conversion, elapsed, alarm sum, hour estimate
   bcdt_front u_front (
      .clock        (clock),
      .ctl          (ctl),
      .sec_bcd      (req_chan.sec_bcd),
      .min_bcd      (req_chan.min_bcd),
      .hour_bcd     (req_chan.hour_bcd),
      .ref_stamp    (req_chan.ref_stamp),
      .alarm_offset (req_chan.alarm_offset),
      .event_stamp  (event_ff),
      .front        (front)
   );

   // alarm sum to hh:mm:ss BCD
   bcdt_split u_split (
      .clock  (clock),
      .ctl    (ctl),
      .front  (front),
      .result (result)
   );

   assign rsp_chan.valid           = ctl.vld[ST_OUT];
   assign rsp_chan.now_seconds     = result.now_seconds;
   assign rsp_chan.elapsed_seconds = result.elapsed_seconds;
   assign rsp_chan.alarm_word      = result.alarm_word;

   // assertions
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> ctl.vld[ST_DECODE])
      else $error("accepted word did not enter the first stage");

   a_event_wrapped: assert property (@(posedge clock) disable iff (reset)
      event_ff < DAY_SECONDS)
      else $error("event stamp not below one day");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.now_seconds < DAY_SECONDS)
                         && (rsp_chan.elapsed_seconds < DAY_SECONDS))
      else $error("result seconds out of range");

   a_word_form: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.alarm_word[31:24] == ALARM_TOP_BYTE)
                         && (rsp_chan.alarm_word[3:0] < 4'd10)
                         && (rsp_chan.alarm_word[11:8] < 4'd10))
      else $error("malformed alarm word");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ctl.vld[ST_OUT] && !rsp_chan.ready |=> ctl.vld[ST_OUT] && $stable(result))
      else $error("stalled result changed");

endmodule

[tb/sv/bcdt_tb_pkg.sv]
`timescale 1ns / 1ps

package bcdt_tb_pkg;

   import bcdt_pkg::*;

   // binary 0..59 to two packed BCD digits
   function automatic logic [7:0] to_bcd(int unsigned v);
      logic [7:0] digits;
      digits[7:4] = 4'(v / 10);
      digits[3:0] = 4'(v % 10);
      return digits;
   endfunction

   // expected-result store for the alarm calculator, with its own copy of event_stamp
   class alarm_calc_scoreboard;
      logic [16:0] event_stamp;
      result_type  expected_q[$];
      int unsigned errors;

      function new();
         event_stamp = '0;
         errors      = 0;
      endfunction

      function void set_event_stamp(logic [16:0] value);
         event_stamp = value;
      endfunction

      // seconds of day, elapsed time and alarm word for one reading
      function result_type predict_reading(logic [6:0] sec_bcd, logic [6:0] min_bcd,
                                           logic [5:0] hour_bcd, logic [16:0] ref_stamp,
                                           logic [15:0] alarm_offset);
         int unsigned secs, mins, hours, day_pos, ref_pos, alarm_pos;
         result_type  res;
         // digits decode as tens*10 + units, no range check on the units
         secs    = 10 * sec_bcd[6:4] + sec_bcd[3:0];
         mins    = 10 * min_bcd[6:4] + min_bcd[3:0];
         hours   = 10 * hour_bcd[5:4] + hour_bcd[3:0];
         day_pos = (hours * HOUR_SECONDS + mins * MIN_SECONDS + secs) % DAY_SECONDS;
         ref_pos = ref_stamp % DAY_SECONDS;
         res.now_seconds     = 17'(day_pos);
         res.elapsed_seconds = (day_pos >= ref_pos) ? 17'(day_pos - ref_pos)
                                                    : 17'(day_pos + DAY_SECONDS - ref_pos);
         // alarm = event_stamp + offset, wrapped at midnight, back to hh:mm:ss
         alarm_pos = (event_stamp % DAY_SECONDS + alarm_offset) % DAY_SECONDS;
         res.alarm_word = {ALARM_TOP_BYTE, to_bcd(alarm_pos / HOUR_SECONDS),
                           to_bcd((alarm_pos % HOUR_SECONDS) / MIN_SECONDS),
                           to_bcd(alarm_pos % MIN_SECONDS)};
         return res;
      endfunction

      function void note_reading(logic [6:0] sec_bcd, logic [6:0] min_bcd,
                                 logic [5:0] hour_bcd, logic [16:0] ref_stamp,
                                 logic [15:0] alarm_offset);
         expected_q.push_back(predict_reading(sec_bcd, min_bcd, hour_bcd, ref_stamp,
                                              alarm_offset));
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected result word: now_seconds %0d elapsed_seconds %0d alarm_word %h",
                   got.now_seconds, got.elapsed_seconds, got.alarm_word);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.now_seconds !== exp.now_seconds) begin
            $error("now_seconds: expected %0d, got %0d", exp.now_seconds, got.now_seconds);
            errors++;
         end
         if (got.elapsed_seconds !== exp.elapsed_seconds) begin
            $error("elapsed_seconds: expected %0d, got %0d",
                   exp.elapsed_seconds, got.elapsed_seconds);
            errors++;
         end
         if (got.alarm_word !== exp.alarm_word) begin
            $error("alarm_word: expected %h, got %h", exp.alarm_word, got.alarm_word);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

[tb/sv/bcd_time_of_day_alarm_calc_tb.sv]
`timescale 1ns / 1ps

module bcd_time_of_day_alarm_calc_tb;

   import bcdt_pkg::*;
   import bcdt_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned PHASE_ITEMS  = 325;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   bcdt_req_if req_chan ();
   bcdt_rsp_if rsp_chan ();

   alarm_calc_scoreboard alarm_sb = new();

   bit          no_idle         = 1'b0;   // both sides run without gaps
   int unsigned rsp_hold_cycles = 0;      // long receiver stall, set by the sender
   int unsigned cycle_count     = 0;

   bcd_time_of_day_alarm_calc dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bcd_time_of_day_alarm_calc_tb: errors");
         $finish;
      end
   end

   // monitors: register writes, accepted input words, accepted result words
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            alarm_sb.set_event_stamp(csr_wr_data);
         if (req_chan.valid && req_chan.ready)
            alarm_sb.note_reading(req_chan.sec_bcd, req_chan.min_bcd, req_chan.hour_bcd,
                                  req_chan.ref_stamp, req_chan.alarm_offset);
         if (rsp_chan.valid && rsp_chan.ready)
            alarm_sb.check_result(result_type'({rsp_chan.now_seconds,
                                                rsp_chan.elapsed_seconds,
                                                rsp_chan.alarm_word}));
      end
   end

   // result side: random gaps, plus one long hold on request
   initial begin
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready) && rsp_hold_cycles == 0);
      end
   end

   // offer one input word and wait until it is taken
   task automatic send_reading(logic [6:0] sec_bcd, logic [6:0] min_bcd, logic [5:0] hour_bcd,
                               logic [16:0] ref_stamp, logic [15:0] alarm_offset);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sec_bcd      <= sec_bcd;
      req_chan.min_bcd      <= min_bcd;
      req_chan.hour_bcd     <= hour_bcd;
      req_chan.ref_stamp    <= ref_stamp;
      req_chan.alarm_offset <= alarm_offset;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // mostly well-formed 24-hour readings, some raw bit patterns
   task automatic send_random_reading();
      int unsigned kind, hours, mins, secs, day_pos;
      logic [16:0] stamp;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
         hours   = $urandom_range(0, 23);
         mins    = $urandom_range(0, 59);
         secs    = $urandom_range(0, 59);
         day_pos = hours * HOUR_SECONDS + mins * MIN_SECONDS + secs;
         // sometimes reference the reading itself or the last second of the day
         case (kind)
            0:       stamp = 17'(day_pos);
            1:       stamp = 17'(DAY_SECONDS - 1);
            default: stamp = 17'($urandom_range(0, DAY_SECONDS - 1));
         endcase
         send_reading(7'(to_bcd(secs)), 7'(to_bcd(mins)), 6'(to_bcd(hours)), stamp,
                      16'($urandom));
      end else begin
         send_reading(7'($urandom), 7'($urandom), 6'($urandom), 17'($urandom), 16'($urandom));
      end
   endtask

   // drop valid and wait for every expected result, then let the pipe settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (alarm_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_event_stamp(logic [16:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random_phase(int unsigned n_items, bit with_hold, bit with_pause);
      if (with_hold) begin
         // receiver stops while the sender streams, so the pipe backs up
         no_idle         = 1'b1;
         rsp_hold_cycles = LONG_HOLD;
      end
      for (int unsigned i = 0; i < n_items; i++) begin
         if (with_hold && i == 60)
            no_idle = 1'b0;
         else if (!with_hold && i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (with_pause && i == n_items / 2)
            drain();
         send_random_reading();
      end
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.sec_bcd      <= '0;
      req_chan.min_bcd      <= '0;
      req_chan.hour_bcd     <= '0;
      req_chan.ref_stamp    <= '0;
      req_chan.alarm_offset <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and corner cases, base at midnight
      write_event_stamp(17'd0);
      send_reading(7'h00, 7'h00, 6'h00, 17'd0, 16'd0);
      send_reading(7'h59, 7'h59, 6'h23, 17'd0, 16'd0);            // last second of day
      send_reading(7'h01, 7'h00, 6'h00, 17'd86399, 16'd1);        // elapsed wraps midnight
      send_reading(7'h56, 7'h34, 6'h12, 17'd45296, 16'd3600);     // zero elapsed
      send_reading(7'h7F, 7'h7F, 6'h3F, 17'h1FFFF, 16'hFFFF);     // every field at max
      send_reading(7'h0F, 7'h0A, 6'h0C, 17'd100, 16'd59);         // non-decimal units digits
      send_reading(7'h00, 7'h00, 6'h24, 17'd5, 16'd60);           // reading of exactly one day
      send_reading(7'h70, 7'h70, 6'h30, 17'd86400, 16'd86);       // past one day, stamp = day
      send_reading(7'h30, 7'h15, 6'h08, 17'd131071, 16'hFFFF);    // stamp beyond one day
      send_reading(7'h00, 7'h00, 6'h00, 17'd1, 16'd0);
      drain();

      // base at the last second of the day: alarm sum wraps
      write_event_stamp(17'd86399);
      send_reading(7'h00, 7'h00, 6'h00, 17'd0, 16'd0);
      send_reading(7'h00, 7'h00, 6'h00, 17'd0, 16'd1);
      send_reading(7'h45, 7'h30, 6'h20, 17'd0, 16'hFFFF);
      send_reading(7'h59, 7'h59, 6'h23, 17'd86399, 16'hAAAA);
      send_reading(7'h2A, 7'h55, 6'h15, 17'h15555, 16'h5555);
      drain();

      // random phases over several base stamps
      write_event_stamp(17'h1FFFF);
      run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);
      write_event_stamp(17'd86400);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
      write_event_stamp(17'd0);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      write_event_stamp(17'($urandom_range(0, DAY_SECONDS - 1)));
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      write_event_stamp(17'd86399);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      write_event_stamp(17'($urandom));
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (alarm_sb.pending() != 0) begin
         $error("%0d expected result words never arrived", alarm_sb.pending());
         alarm_sb.errors += alarm_sb.pending();
      end
      if (alarm_sb.errors == 0)
         $display("bcd_time_of_day_alarm_calc_tb: clean");
      else
         $display("bcd_time_of_day_alarm_calc_tb: errors");
      $finish;
   end

endmodule
